### sv/lat_pkg.sv
// Shared types and constants for the toroidal life grid.
`default_nettype none

package lat_pkg;

    localparam int COORD_W = 6;

    // Operation codes carried in func
    localparam logic [1:0] FUNC_WRITE = 2'd0;
    localparam logic [1:0] FUNC_STEP  = 2'd1;
    localparam logic [1:0] FUNC_READ  = 2'd2;

    // Result kinds
    localparam logic KIND_READ = 1'b0;
    localparam logic KIND_STEP = 1'b1;

    // B3/S23 neighbour counts
    localparam int          NBR_CNT_W     = 4;
    localparam logic [3:0]  BIRTH_COUNT   = 4'd3;
    localparam logic [3:0]  SURVIVE_COUNT = 4'd2;

    typedef struct packed {
        logic [1:0]         func;
        logic [COORD_W-1:0] col;
        logic [COORD_W-1:0] row;
        logic               alive_in;
    } in_item_t;

    typedef struct packed {
        logic result_kind;
        logic cell_alive;
    } out_item_t;

    // Controls from the sequencer to the row window
    typedef struct packed {
        logic load_n;
        logic load_c;
        logic load_s;
        logic shift;
    } win_ctl_t;

endpackage

`default_nettype wire

### sv/lat_ram.sv
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module lat_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 64
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

### sv/lat_rule.sv
// Neighbour count and B3/S23 decision for one cell.
`default_nettype none

module lat_rule (
    input  wire logic [7:0] nbr,
    input  wire logic       alive,
    output logic            alive_next
);

    import lat_pkg::*;

    logic [NBR_CNT_W-1:0] cnt;

    always_comb
    begin
        cnt = '0;
        for (int i = 0; i < 8; i++)
        begin
            cnt = cnt + NBR_CNT_W'(nbr[i]);
        end
        alive_next = (cnt == BIRTH_COUNT) || (alive && (cnt == SURVIVE_COUNT));
    end

endmodule

`default_nettype wire

### sv/lat_window.sv
// Three-row rotating window and next-row builder around the shared rule unit.
`default_nettype none

module lat_window #(
    parameter int WIDTH = 64
) (
    input  wire logic              clk,
    input  wire lat_pkg::win_ctl_t ctl,
    input  wire logic [WIDTH-1:0]  row_data,
    output logic      [WIDTH-1:0]  next_row
);

    import lat_pkg::*;

    logic [WIDTH-1:0] north_reg;
    logic [WIDTH-1:0] centre_reg;
    logic [WIDTH-1:0] south_reg;
    logic [WIDTH-1:0] next_reg;
    logic [7:0]       nbr;
    logic             cell_next;

    // Bit 0 is the current column, bit 1 its east and the top bit its west
    assign nbr = {north_reg[WIDTH-1], north_reg[0], north_reg[1],
                  centre_reg[WIDTH-1], centre_reg[1],
                  south_reg[WIDTH-1], south_reg[0], south_reg[1]};

    lat_rule u_rule (
        .nbr        (nbr),
        .alive      (centre_reg[0]),
        .alive_next (cell_next)
    );

    always_ff @(posedge clk)
    begin
        if (ctl.load_n)
        begin
            north_reg <= row_data;
        end
        if (ctl.load_c)
        begin
            centre_reg <= row_data;
        end
        if (ctl.load_s)
        begin
            south_reg <= row_data;
        end
        if (ctl.shift)
        begin
            // rotate one column on; the new cell enters at the top
            north_reg  <= {north_reg[0], north_reg[WIDTH-1:1]};
            centre_reg <= {centre_reg[0], centre_reg[WIDTH-1:1]};
            south_reg  <= {south_reg[0], south_reg[WIDTH-1:1]};
            next_reg   <= {cell_next, next_reg[WIDTH-1:1]};
        end
    end

    assign next_row = next_reg;

endmodule

`default_nettype wire

### sv/life_automaton_toroidal_grid_unit.sv
// Top level: toroidal life grid with sequencer, ping-pong row banks and output register.
//
//   channel | dir | payload            | handshake
//   in      | in  | in_data (in_item)  | in_valid / in_stall
//   out     | out | out_data (out_item)| out_valid / out_stall
//
// A write reads its row and writes it back; a read passes S_READ and S_EMIT to its result register.
// A step walks the grid row by row: it fetches the north, centre and south rows
// from the bank port into the window, passes each column through the rule unit and
// stores the new row; the accept and emit states frame the pass.
// After reset a clearing pass over every row of bank 0 holds in_stall high.
// in_stall is low only while the sequencer is idle; a stalled result is held.
`default_nettype none

module life_automaton_toroidal_grid_unit #(
    parameter int GRID_WIDTH  = 64,
    parameter int GRID_HEIGHT = 64
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               in_valid,
    output logic                    in_stall,
    input  wire lat_pkg::in_item_t  in_data,
    output logic                    out_valid,
    input  wire logic               out_stall,
    output lat_pkg::out_item_t      out_data
);

    import lat_pkg::*;

    localparam int CW = $clog2(GRID_WIDTH);
    localparam int RW = $clog2(GRID_HEIGHT);
    localparam logic [CW-1:0] COL_LAST = CW'(GRID_WIDTH - 1);
    localparam logic [RW-1:0] ROW_LAST = RW'(GRID_HEIGHT - 1);

    typedef enum logic [7:0] {
        S_CLEAR = 8'b0000_0001,
        S_IDLE  = 8'b0000_0010,
        S_WRITE = 8'b0000_0100,
        S_READ  = 8'b0000_1000,
        S_FETCH = 8'b0001_0000,
        S_SWEEP = 8'b0010_0000,
        S_STORE = 8'b0100_0000,
        S_EMIT  = 8'b1000_0000
    } state_t;

    state_t          state_reg, state_next;
    logic [RW-1:0]   row_reg, row_next;
    logic [CW-1:0]   col_reg, col_next;
    logic [1:0]      fetch_reg, fetch_next;
    logic            cur_reg, cur_next;
    logic            alive_reg, alive_next;
    logic            inside_reg, inside_next;
    logic            res_kind_reg, res_kind_next;
    logic            res_bit_reg, res_bit_next;
    logic            out_valid_reg, out_valid_next;
    out_item_t       out_data_reg, out_data_next;

    logic [RW-1:0]         raddr;
    logic [RW-1:0]         row_north;
    logic [RW-1:0]         row_south;
    logic [GRID_WIDTH-1:0] rdata0, rdata1, rdata_cur;
    logic [GRID_WIDTH-1:0] wdata;
    logic [GRID_WIDTH-1:0] next_row;
    logic                  we0, we1;
    logic                  in_inside;
    logic                  out_free;
    win_ctl_t              win_ctl;

    assign rdata_cur = cur_reg ? rdata1 : rdata0;
    assign row_north = (row_reg == '0) ? ROW_LAST : row_reg - RW'(1);
    assign row_south = (row_reg == ROW_LAST) ? '0 : row_reg + RW'(1);
    assign in_inside = (32'(in_data.col) < GRID_WIDTH) && (32'(in_data.row) < GRID_HEIGHT);
    assign out_free  = !out_valid_reg || !out_stall;

    lat_ram #(.WIDTH(GRID_WIDTH), .DEPTH(GRID_HEIGHT)) u_bank0 (
        .clk   (clk),
        .we    (we0),
        .waddr (row_reg),
        .wdata (wdata),
        .raddr (raddr),
        .rdata (rdata0)
    );

    lat_ram #(.WIDTH(GRID_WIDTH), .DEPTH(GRID_HEIGHT)) u_bank1 (
        .clk   (clk),
        .we    (we1),
        .waddr (row_reg),
        .wdata (wdata),
        .raddr (raddr),
        .rdata (rdata1)
    );

    lat_window #(.WIDTH(GRID_WIDTH)) u_window (
        .clk      (clk),
        .ctl      (win_ctl),
        .row_data (rdata_cur),
        .next_row (next_row)
    );

    always_comb
    begin
        state_next     = state_reg;
        row_next       = row_reg;
        col_next       = col_reg;
        fetch_next     = fetch_reg;
        cur_next       = cur_reg;
        alive_next     = alive_reg;
        inside_next    = inside_reg;
        res_kind_next  = res_kind_reg;
        res_bit_next   = res_bit_reg;
        out_valid_next = out_valid_reg;
        out_data_next  = out_data_reg;
        raddr          = row_reg;
        wdata          = next_row;
        we0            = 1'b0;
        we1            = 1'b0;
        win_ctl        = '0;
        in_stall       = 1'b1;

        // drop the beat once taken
        if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_CLEAR:
            begin
                wdata = '0;
                we0   = 1'b1;
                if (row_reg == ROW_LAST)
                begin
                    row_next   = '0;
                    state_next = S_IDLE;
                end
                else
                begin
                    row_next = row_reg + RW'(1);
                end
            end
            S_IDLE:
            begin
                in_stall = 1'b0;
                raddr    = RW'(in_data.row);
                if (in_valid)
                begin
                    row_next    = RW'(in_data.row);
                    col_next    = CW'(in_data.col);
                    alive_next  = in_data.alive_in;
                    inside_next = in_inside;
                    unique case (in_data.func)
                        FUNC_WRITE:
                        begin
                            if (in_inside)
                            begin
                                state_next = S_WRITE;
                            end
                        end
                        FUNC_READ:
                        begin
                            state_next = S_READ;
                        end
                        FUNC_STEP:
                        begin
                            row_next   = '0;
                            fetch_next = '0;
                            state_next = S_FETCH;
                        end
                        default:
                        begin
                            // unused code: drop the beat
                            state_next = S_IDLE;
                        end
                    endcase
                end
            end
            S_WRITE:
            begin
                wdata          = rdata_cur;
                wdata[col_reg] = alive_reg;
                we0            = !cur_reg;
                we1            = cur_reg;
                state_next     = S_IDLE;
            end
            S_READ:
            begin
                res_kind_next = KIND_READ;
                res_bit_next  = inside_reg && rdata_cur[col_reg];
                state_next    = S_EMIT;
            end
            S_FETCH:
            begin
                unique case (fetch_reg)
                    2'd0:    raddr = row_north;
                    2'd1:    raddr = row_reg;
                    2'd2:    raddr = row_south;
                    default: raddr = row_reg;
                endcase
                win_ctl.load_n = (fetch_reg == 2'd1);
                win_ctl.load_c = (fetch_reg == 2'd2);
                win_ctl.load_s = (fetch_reg == 2'd3);
                fetch_next     = fetch_reg + 2'd1;
                if (fetch_reg == 2'd3)
                begin
                    col_next   = '0;
                    state_next = S_SWEEP;
                end
            end
            S_SWEEP:
            begin
                win_ctl.shift = 1'b1;
                col_next      = col_reg + CW'(1);
                if (col_reg == COL_LAST)
                begin
                    state_next = S_STORE;
                end
            end
            S_STORE:
            begin
                // the new generation goes to the other bank
                we0        = cur_reg;
                we1        = !cur_reg;
                fetch_next = '0;
                if (row_reg == ROW_LAST)
                begin
                    cur_next      = !cur_reg;
                    res_kind_next = KIND_STEP;
                    res_bit_next  = 1'b0;
                    state_next    = S_EMIT;
                end
                else
                begin
                    row_next   = row_reg + RW'(1);
                    state_next = S_FETCH;
                end
            end
            S_EMIT:
            begin
                if (out_free)
                begin
                    out_valid_next            = 1'b1;
                    out_data_next.result_kind = res_kind_reg;
                    out_data_next.cell_alive  = res_bit_reg;
                    state_next                = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            row_reg       <= '0;
            col_reg       <= '0;
            fetch_reg     <= '0;
            cur_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            row_reg       <= row_next;
            col_reg       <= col_next;
            fetch_reg     <= fetch_next;
            cur_reg       <= cur_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        alive_reg    <= alive_next;
        inside_reg   <= inside_next;
        res_kind_reg <= res_kind_next;
        res_bit_reg  <= res_bit_next;
        out_data_reg <= out_data_next;
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

endmodule

`default_nettype wire

### tb/life_grid_checker.sv
// Checker for the life grid: mirrors the cells, predicts every reply and compares it.
`timescale 1ns / 100ps

module life_grid_checker #(
    parameter int GRID_W = 64,
    parameter int GRID_H = 64
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               in_valid,
    input  wire logic               in_stall,
    input  wire lat_pkg::in_item_t  in_data,
    input  wire logic               out_valid,
    input  wire logic               out_stall,
    input  wire lat_pkg::out_item_t out_data,
    output int                      replies_pending,
    output int                      mismatches
);

    import lat_pkg::*;

    logic [GRID_W-1:0] cells [GRID_H];
    out_item_t         replies_due [$];
    int                err_total = 0;

    assign mismatches = err_total;

    function automatic logic [3:0] live_neighbours(input int c, input int r);
        int         west;
        int         east;
        int         north;
        int         south;
        logic [3:0] n;
        west  = (c + GRID_W - 1) % GRID_W;
        east  = (c + 1) % GRID_W;
        north = (r + GRID_H - 1) % GRID_H;
        south = (r + 1) % GRID_H;
        n = cells[north][west] + cells[north][c] + cells[north][east]
          + cells[r][west] + cells[r][east]
          + cells[south][west] + cells[south][c] + cells[south][east];
        return n;
    endfunction

    // Build the whole next generation from the old one before touching any cell
    task automatic advance_generation();
        logic [GRID_W-1:0] fresh [GRID_H];
        logic [3:0]        n;
        for (int r = 0; r < GRID_H; r++)
        begin
            for (int c = 0; c < GRID_W; c++)
            begin
                n = live_neighbours(c, r);
                fresh[r][c] = (n == BIRTH_COUNT) || (cells[r][c] && (n == SURVIVE_COUNT));
            end
        end
        for (int r = 0; r < GRID_H; r++)
            cells[r] = fresh[r];
    endtask

    task automatic apply_grid_op(input in_item_t beat);
        out_item_t reply;
        logic      on_grid;
        on_grid = (beat.col < GRID_W) && (beat.row < GRID_H);
        case (beat.func)
            FUNC_WRITE:
            begin
                if (on_grid)
                    cells[beat.row][beat.col] = beat.alive_in;
            end
            FUNC_STEP:
            begin
                advance_generation();
                reply.result_kind = KIND_STEP;
                reply.cell_alive  = 1'b0;
                replies_due.push_back(reply);
            end
            FUNC_READ:
            begin
                reply.result_kind = KIND_READ;
                reply.cell_alive  = on_grid ? cells[beat.row][beat.col] : 1'b0;
                replies_due.push_back(reply);
            end
            default:
            begin
                // unused code: drop the beat
            end
        endcase
    endtask

    always @(posedge clk or negedge rst_n)
    begin : watch
        out_item_t want;
        if (!rst_n)
        begin
            for (int r = 0; r < GRID_H; r++)
                cells[r] = '0;
            replies_due.delete();
            replies_pending <= 0;
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                if (replies_due.size() == 0)
                begin
                    $display("%0t: result with none expected, actual kind %0b alive %0b",
                             $time, out_data.result_kind, out_data.cell_alive);
                    err_total++;
                end
                else
                begin
                    want = replies_due.pop_front();
                    if (out_data.result_kind !== want.result_kind)
                    begin
                        $display("%0t: result_kind expected %0b actual %0b",
                                 $time, want.result_kind, out_data.result_kind);
                        err_total++;
                    end
                    if (out_data.cell_alive !== want.cell_alive)
                    begin
                        $display("%0t: cell_alive expected %0b actual %0b",
                                 $time, want.cell_alive, out_data.cell_alive);
                        err_total++;
                    end
                end
            end
            if (in_valid && !in_stall)
                apply_grid_op(in_data);
            replies_pending <= replies_due.size();
        end
    end

endmodule

### tb/life_automaton_toroidal_grid_unit_tb.sv
// Testbench top for the toroidal life grid: stimulus, receiver stalls, watchdog and verdict.
`timescale 1ns / 100ps

module life_automaton_toroidal_grid_unit_tb;
    import lat_pkg::*;

    localparam logic [1:0] FUNC_UNUSED = 2'd3;
    localparam int         ITEM_TARGET = 140;
    // a step alone keeps both channels quiet for its whole sweep over the grid
    localparam int         IDLE_LIMIT  = 20000;

    logic      clk;
    logic      rst_n     = 1'b0;
    logic      in_valid  = 1'b0;
    logic      in_stall;
    in_item_t  in_data   = '0;
    logic      out_valid;
    logic      out_stall = 1'b0;
    out_item_t out_data;

    int replies_pending;
    int mismatches;
    int items_sent  = 0;
    int burst_left  = 4;
    int idle_cycles = 0;
    int stall_mode  = 0;
    int stall_phase = 0;

    life_automaton_toroidal_grid_unit uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data)
    );

    life_grid_checker #(
        .GRID_W (64),
        .GRID_H (64)
    ) grid_watch (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_valid        (in_valid),
        .in_stall        (in_stall),
        .in_data         (in_data),
        .out_valid       (out_valid),
        .out_stall       (out_stall),
        .out_data        (out_data),
        .replies_pending (replies_pending),
        .mismatches      (mismatches)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Receiver: stretches of no stall, light stall and heavy stall
    always @(posedge clk)
    begin
        if (stall_phase == 0)
        begin
            stall_mode  <= $urandom_range(0, 2);
            stall_phase <= $urandom_range(16, 80);
        end
        else
            stall_phase <= stall_phase - 1;
        case (stall_mode)
            0:       out_stall <= 1'b0;
            1:       out_stall <= ($urandom_range(0, 1) == 1);
            default: out_stall <= ($urandom_range(0, 3) != 0);
        endcase
    end

    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("tb: failure");
            $finish;
        end
    end

    // Present one beat and hold it until accepted; close the burst with a random gap
    task automatic issue_cell_op(input logic [1:0] f, input logic [COORD_W-1:0] c,
                                 input logic [COORD_W-1:0] r, input logic a);
        in_item_t beat;
        beat.func     = f;
        beat.col      = c;
        beat.row      = r;
        beat.alive_in = a;
        in_data  <= beat;
        in_valid <= 1'b1;
        do
            @(posedge clk);
        while (in_stall);
        if (f != FUNC_UNUSED)
            items_sent++;
        burst_left--;
        if (burst_left <= 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge clk);
            burst_left = ($urandom_range(0, 3) == 0) ? 40 : $urandom_range(1, 10);
        end
    endtask

    task automatic hold_until_drained();
        in_valid <= 1'b0;
        do
            @(posedge clk);
        while (replies_pending != 0);
    endtask

    initial
    begin
        logic [COORD_W-1:0] ox;
        logic [COORD_W-1:0] oy;
        int                 w;
        int                 h;

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        // grid must come out of reset empty, corners included
        issue_cell_op(FUNC_READ, 6'd0, 6'd0, 1'b1);
        issue_cell_op(FUNC_READ, 6'd63, 6'd63, 1'b0);
        issue_cell_op(FUNC_WRITE, 6'd0, 6'd0, 1'b1);
        issue_cell_op(FUNC_WRITE, 6'd63, 6'd63, 1'b1);
        issue_cell_op(FUNC_READ, 6'd0, 6'd0, 1'b0);
        issue_cell_op(FUNC_READ, 6'd63, 6'd63, 1'b1);
        issue_cell_op(FUNC_WRITE, 6'd63, 6'd63, 1'b0);
        issue_cell_op(FUNC_READ, 6'd63, 6'd63, 1'b0);
        issue_cell_op(FUNC_UNUSED, 6'd63, 6'd63, 1'b1);
        // blinkers straddling the east-west and the north-south seams
        issue_cell_op(FUNC_WRITE, 6'd62, 6'd0, 1'b1);
        issue_cell_op(FUNC_WRITE, 6'd63, 6'd0, 1'b1);
        issue_cell_op(FUNC_WRITE, 6'd32, 6'd63, 1'b1);
        issue_cell_op(FUNC_WRITE, 6'd32, 6'd0, 1'b1);
        issue_cell_op(FUNC_WRITE, 6'd32, 6'd1, 1'b1);
        issue_cell_op(FUNC_STEP, 6'd63, 6'd63, 1'b1);
        issue_cell_op(FUNC_READ, 6'd63, 6'd63, 1'b0);
        issue_cell_op(FUNC_READ, 6'd63, 6'd1, 1'b0);
        issue_cell_op(FUNC_READ, 6'd62, 6'd0, 1'b0);
        issue_cell_op(FUNC_READ, 6'd31, 6'd0, 1'b0);
        issue_cell_op(FUNC_READ, 6'd33, 6'd0, 1'b0);
        issue_cell_op(FUNC_READ, 6'd32, 6'd63, 1'b0);
        issue_cell_op(FUNC_STEP, 6'd0, 6'd0, 1'b0);
        issue_cell_op(FUNC_READ, 6'd62, 6'd0, 1'b1);
        issue_cell_op(FUNC_READ, 6'd32, 6'd63, 1'b1);
        hold_until_drained();

        // seed a small random patch anywhere, maybe evolve it, then probe around it
        while (items_sent < ITEM_TARGET)
        begin
            ox = $urandom;
            oy = $urandom;
            w  = $urandom_range(3, 4);
            h  = $urandom_range(3, 4);
            for (int dy = 0; dy < h; dy++)
                for (int dx = 0; dx < w; dx++)
                    issue_cell_op(FUNC_WRITE, ox + dx, oy + dy, $urandom_range(0, 1));
            if ($urandom_range(0, 2) == 0)
                issue_cell_op(FUNC_UNUSED, $urandom, $urandom, $urandom);
            repeat ($urandom_range(0, 2))
                issue_cell_op(FUNC_STEP, $urandom, $urandom, $urandom);
            if ($urandom_range(0, 3) == 0)
                hold_until_drained();
            repeat (8)
                issue_cell_op(FUNC_READ, ox + $urandom_range(0, 7) - 2,
                              oy + $urandom_range(0, 7) - 2, $urandom);
            if ($urandom_range(0, 1) == 0)
                issue_cell_op($urandom_range(0, 1) ? FUNC_READ : FUNC_WRITE,
                              $urandom, $urandom, $urandom);
        end

        hold_until_drained();
        repeat (16) @(posedge clk);
        if (mismatches == 0 && replies_pending == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
